>>> rtl/prpq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// prpq_pkg
// Shared sizes, codes and types for the process ready priority queue.
// ----------------------------------------------------------------------------
package prpq_pkg;

  // Sizes
  localparam int QUEUE_DEPTH = 16;
  localparam int ID_BITS     = 8;
  localparam int TIME_BITS   = 32;
  localparam int IDX_BITS    = $clog2(QUEUE_DEPTH);
  localparam int CNT_BITS    = $clog2(QUEUE_DEPTH + 1);

  // Operation kinds
  localparam logic [1:0] KIND_INSERT = 2'd0;
  localparam logic [1:0] KIND_POP    = 2'd1;
  localparam logic [1:0] KIND_SETB   = 2'd2;
  localparam logic [1:0] KIND_ROTATE = 2'd3;

  // Order modes (the unused code behaves as FIFO)
  localparam logic [1:0] MODE_FIFO = 2'd0;
  localparam logic [1:0] MODE_FCFS = 2'd1;
  localparam logic [1:0] MODE_SRTF = 2'd2;

  // Result status
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_EMPTY = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;

  // Cell commands
  localparam logic [2:0] CELL_HOLD   = 3'd0;
  localparam logic [2:0] CELL_INSERT = 3'd1;
  localparam logic [2:0] CELL_POP    = 3'd2;
  localparam logic [2:0] CELL_SETB   = 3'd3;
  localparam logic [2:0] CELL_ROTATE = 3'd4;

  typedef struct packed {
    logic [ID_BITS-1:0]   id;
    logic [TIME_BITS-1:0] arrival;
    logic [TIME_BITS-1:0] burst;
  } rec_t;

  // Running best candidate of the search wave
  typedef struct packed {
    logic [IDX_BITS-1:0] idx;
    rec_t                rec;
  } wave_t;

  // Broadcast from the sequencer to every cell
  typedef struct packed {
    logic [2:0]          op;
    logic [IDX_BITS-1:0] target;
    rec_t                rec;
  } cell_cmd_t;

endpackage
`default_nettype wire

>>> rtl/prpq_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// prpq_cell
// One queue slot: holds a record and passes the search wave to its neighbor.
// ----------------------------------------------------------------------------
module prpq_cell (
  input  wire                                clk,
  input  wire  [prpq_pkg::IDX_BITS-1:0]      idx,
  input  wire  [prpq_pkg::CNT_BITS-1:0]      occupancy,
  input  wire  [1:0]                         order_mode,
  input  wire  prpq_pkg::cell_cmd_t          cmd,
  input  wire  prpq_pkg::rec_t               next_rec,
  input  wire  prpq_pkg::rec_t               wrap_rec,
  input  wire  prpq_pkg::wave_t              prev_wave,
  output prpq_pkg::rec_t                     rec,
  output prpq_pkg::wave_t                    wave
);

  localparam int CW = prpq_pkg::CNT_BITS;

  logic            own_valid;
  logic            own_first;
  logic [prpq_pkg::TIME_BITS-1:0] own_key;
  logic [prpq_pkg::TIME_BITS-1:0] prev_key;
  logic            ordered;
  logic            own_before;
  prpq_pkg::wave_t wave_next;

  assign own_valid = CW'(idx) < occupancy;
  assign own_first = (idx == '0);
  assign ordered   = (order_mode == prpq_pkg::MODE_FCFS) ||
                     (order_mode == prpq_pkg::MODE_SRTF);

  // Pick the sort key for the current mode
  always_comb begin
    if (order_mode == prpq_pkg::MODE_FCFS) begin
      own_key  = rec.arrival;
      prev_key = prev_wave.rec.arrival;
    end else begin
      own_key  = rec.burst;
      prev_key = prev_wave.rec.burst;
    end
  end

  // This record beats the wave only when strictly ahead; ties go by lower id
  assign own_before = ordered &&
                      ((own_key < prev_key) ||
                       ((own_key == prev_key) && (rec.id < prev_wave.rec.id)));

  // Advance the wave by one cell
  always_comb begin
    wave_next = prev_wave;
    if (own_valid && (own_first || own_before)) begin
      wave_next.idx = idx;
      wave_next.rec = rec;
    end
  end

  always_ff @(posedge clk) begin
    wave <= wave_next;
  end

  // Update the held record
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      prpq_pkg::CELL_INSERT: begin
        if (idx == cmd.target) rec <= cmd.rec;
      end
      prpq_pkg::CELL_POP: begin
        if (idx >= cmd.target) rec <= next_rec;
      end
      prpq_pkg::CELL_SETB: begin
        if (idx == cmd.target) rec.burst <= cmd.rec.burst;
      end
      prpq_pkg::CELL_ROTATE: begin
        if (idx == cmd.target) begin
          rec <= wrap_rec;
        end else if (idx < cmd.target) begin
          rec <= next_rec;
        end
      end
      default: begin
        rec <= rec;
      end
    endcase
  end

endmodule
`default_nettype wire

>>> rtl/process_ready_priority_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// process_ready_priority_queue
// Ready queue of process records with FIFO, FCFS and SRTF head selection.
// ----------------------------------------------------------------------------
// Pulse start while busy is low to issue one operation; the result appears on
// the head and status ports for exactly one cycle with done high and must be
// taken then, since the block never waits for the receiver. An operation on an
// empty queue (other than insert) reports in the cycle after start. Every other
// operation runs a search over the whole row of cells from start to done:
// the head is found by a search wave that walks the row of cells one cell per
// clock, and the block accepts the next operation in the cycle done is high.
// Write order_mode only while busy is low and no result is pending.
module process_ready_priority_queue (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire                                 order_mode_we,
  input  wire  [1:0]                          order_mode_wdata,
  input  wire                                 start,
  output logic                                busy,
  input  wire  [1:0]                          kind,
  input  wire  [prpq_pkg::ID_BITS-1:0]        proc_id,
  input  wire  [prpq_pkg::TIME_BITS-1:0]      arrival,
  input  wire  [prpq_pkg::TIME_BITS-1:0]      burst,
  output logic                                done,
  output logic [prpq_pkg::ID_BITS-1:0]        head_id,
  output logic [prpq_pkg::TIME_BITS-1:0]      head_arrival,
  output logic [prpq_pkg::TIME_BITS-1:0]      head_burst,
  output logic [1:0]                          status,
  output logic [prpq_pkg::CNT_BITS-1:0]       entry_count
);

  localparam int DEPTH = prpq_pkg::QUEUE_DEPTH;
  localparam int IW    = prpq_pkg::IDX_BITS;
  localparam int CW    = prpq_pkg::CNT_BITS;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;

  logic [1:0]                   state, state_next;
  logic [CW-1:0]                scan_cnt, scan_cnt_next;
  logic [CW-1:0]                occupancy, occupancy_next;
  logic [1:0]                   order_mode;
  logic [1:0]                   op_kind;
  logic [1:0]                   op_status;
  logic [prpq_pkg::TIME_BITS-1:0] op_burst;
  logic                         accept;
  logic                         fifo_like;
  logic                         scan_last;
  prpq_pkg::cell_cmd_t          cmd;
  prpq_pkg::rec_t               in_rec;
  prpq_pkg::rec_t               cell_rec  [DEPTH];
  prpq_pkg::wave_t              cell_wave [DEPTH];
  prpq_pkg::wave_t              best;

  assign busy      = (state != ST_IDLE);
  assign accept    = start && !busy;
  assign fifo_like = (order_mode != prpq_pkg::MODE_FCFS) &&
                     (order_mode != prpq_pkg::MODE_SRTF);
  assign scan_last = (state == ST_SCAN) && (scan_cnt == CW'(DEPTH));
  assign best      = cell_wave[DEPTH-1];

  assign in_rec.id      = proc_id;
  assign in_rec.arrival = arrival;
  assign in_rec.burst   = burst;

  // Row of cells
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    prpq_pkg::rec_t  nbr_rec;
    prpq_pkg::wave_t nbr_wave;
    if (g == DEPTH - 1) begin : g_tail
      assign nbr_rec = '0;
    end else begin : g_body
      assign nbr_rec = cell_rec[g+1];
    end
    if (g == 0) begin : g_head
      assign nbr_wave = '0;
    end else begin : g_rest
      assign nbr_wave = cell_wave[g-1];
    end
    prpq_cell u_cell (
      .clk        (clk),
      .idx        (IW'(g)),
      .occupancy  (occupancy),
      .order_mode (order_mode),
      .cmd        (cmd),
      .next_rec   (nbr_rec),
      .wrap_rec   (cell_rec[0]),
      .prev_wave  (nbr_wave),
      .rec        (cell_rec[g]),
      .wave       (cell_wave[g])
    );
  end

  // Sequence the operation and drive the cell command
  always_comb begin
    state_next     = state;
    scan_cnt_next  = scan_cnt;
    occupancy_next = occupancy;
    cmd.op         = prpq_pkg::CELL_HOLD;
    cmd.target     = best.idx;
    cmd.rec        = in_rec;
    unique case (state)
      ST_IDLE: begin
        scan_cnt_next = '0;
        if (accept) begin
          if (kind == prpq_pkg::KIND_INSERT) begin
            state_next = ST_SCAN;
            if (occupancy < CW'(DEPTH)) begin
              cmd.op         = prpq_pkg::CELL_INSERT;
              cmd.target     = occupancy[IW-1:0];
              occupancy_next = occupancy + 1'b1;
            end
          end else if (occupancy != '0) begin
            state_next = ST_SCAN;
            if ((kind == prpq_pkg::KIND_ROTATE) && fifo_like) begin
              cmd.op     = prpq_pkg::CELL_ROTATE;
              cmd.target = occupancy[IW-1:0] - 1'b1;
            end
          end
        end
      end
      ST_SCAN: begin
        scan_cnt_next = scan_cnt + 1'b1;
        if (scan_last) begin
          state_next = ST_IDLE;
          if (op_kind == prpq_pkg::KIND_POP) begin
            cmd.op         = prpq_pkg::CELL_POP;
            occupancy_next = occupancy - 1'b1;
          end else if (op_kind == prpq_pkg::KIND_SETB) begin
            cmd.op        = prpq_pkg::CELL_SETB;
            cmd.rec.burst = op_burst;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      scan_cnt   <= '0;
      occupancy  <= '0;
      order_mode <= prpq_pkg::MODE_FIFO;
      done       <= 1'b0;
    end else begin
      state     <= state_next;
      scan_cnt  <= scan_cnt_next;
      occupancy <= occupancy_next;
      done      <= (accept && (kind != prpq_pkg::KIND_INSERT) && (occupancy == '0)) ||
                   scan_last;
      if (order_mode_we) order_mode <= order_mode_wdata;
    end
  end

  // Hold the operation and drive the result
  always_ff @(posedge clk) begin
    if (accept) begin
      op_kind  <= kind;
      op_burst <= burst;
      if ((kind == prpq_pkg::KIND_INSERT) && (occupancy >= CW'(DEPTH))) begin
        op_status <= prpq_pkg::STAT_FULL;
      end else begin
        op_status <= prpq_pkg::STAT_OK;
      end
      if ((kind != prpq_pkg::KIND_INSERT) && (occupancy == '0)) begin
        head_id      <= '0;
        head_arrival <= '0;
        head_burst   <= '0;
        status       <= prpq_pkg::STAT_EMPTY;
        entry_count  <= occupancy;
      end
    end
    if (scan_last) begin
      head_id      <= best.rec.id;
      head_arrival <= best.rec.arrival;
      head_burst   <= (op_kind == prpq_pkg::KIND_SETB) ? op_burst : best.rec.burst;
      status       <= op_status;
      entry_count  <= occupancy_next;
    end
  end

  // Checks
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy) || $past(start))
    else $error("result strobe without an operation in flight");

  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occupancy <= CW'(DEPTH))
    else $error("occupancy beyond queue depth");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    (done && (status == prpq_pkg::STAT_FULL)) |-> (entry_count == CW'(DEPTH)))
    else $error("full status with queue not full");

  a_scan_no_change: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_SCAN) && !scan_last) |=> $stable(occupancy))
    else $error("occupancy changed during head search");

endmodule
`default_nettype wire
